### hw/rtl/cbd_pkg.sv
// Shared types, constants and helpers for the chunked body deframer.
`default_nettype none
package cbd_pkg;

	localparam int LINE_KEEP_DEF = 15;

	localparam int CAP_W   = 21;
	localparam int TICK_W  = 16;
	localparam int SIZE_W  = 31;

	localparam logic [CAP_W-1:0]  BODY_CAP_RST    = CAP_W'(256 * 1024);
	localparam logic [TICK_W-1:0] STALL_TICKS_RST = TICK_W'(15000);
	localparam logic [SIZE_W-1:0] SIZE_MAX        = '1;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// register indexes on the configuration port
	localparam logic CFG_BODY_CAP    = 1'b0;
	localparam logic CFG_STALL_TICKS = 1'b1;

	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_DATA   = 3'd1,
		PH_TRAIL1 = 3'd2,
		PH_TRAIL2 = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] byte_value;
	} cbd_in_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       finished;
		logic       stalled;
		logic       capped;
	} cbd_out_t;

	typedef struct packed {
		logic [CAP_W-1:0]  body_cap;
		logic [TICK_W-1:0] stall_ticks;
	} cbd_cfg_t;

	// {is_hex, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cbd_core.sv
// Deframer state and combinational next-state logic for one item.
`default_nettype none
module cbd_core #(
	parameter int LINE_KEEP = cbd_pkg::LINE_KEEP_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               fire,
	input  cbd_pkg::cbd_in_t  item,
	input  cbd_pkg::cbd_cfg_t cfg,
	output cbd_pkg::cbd_out_t result
);

	localparam int KEPT_W = $clog2(LINE_KEEP + 1);

	cbd_pkg::phase_t                   phase_q, phase_d;
	logic [cbd_pkg::SIZE_W-1:0]        accum_q, accum_d;
	logic [KEPT_W-1:0]                 kept_q, kept_d;
	logic                              open_q, open_d;
	logic [cbd_pkg::SIZE_W-1:0]        chunk_q, chunk_d;
	logic [cbd_pkg::CAP_W-1:0]         total_q, total_d;
	logic [cbd_pkg::TICK_W-1:0]        idle_q, idle_d;
	logic                              stall_flag_q, stall_flag_d;
	logic                              cap_flag_q, cap_flag_d;

	logic                              active;
	logic                              at_cap;
	logic [cbd_pkg::TICK_W:0]          idle_inc;
	logic [4:0]                        hx;

	assign active = (phase_q == cbd_pkg::PH_SIZE) || (phase_q == cbd_pkg::PH_DATA) ||
		(phase_q == cbd_pkg::PH_TRAIL1) || (phase_q == cbd_pkg::PH_TRAIL2);
	assign at_cap   = total_q >= cfg.body_cap;
	assign idle_inc = {1'b0, idle_q} + 1'b1;
	assign hx       = cbd_pkg::hex_digit(item.byte_value);

	// next state
	always_comb begin
		phase_d      = phase_q;
		accum_d      = accum_q;
		kept_d       = kept_q;
		open_d       = open_q;
		chunk_d      = chunk_q;
		total_d      = total_q;
		idle_d       = idle_q;
		stall_flag_d = stall_flag_q;
		cap_flag_d   = cap_flag_q;
		if (fire && active) begin
			if (at_cap) begin
				phase_d      = cbd_pkg::PH_DONE;
				stall_flag_d = 1'b0;
				cap_flag_d   = 1'b1;
			end else if (item.mode) begin
				idle_d = idle_inc[cbd_pkg::TICK_W] ? '1 : idle_inc[cbd_pkg::TICK_W-1:0];
				if (idle_inc >= {1'b0, cfg.stall_ticks}) begin
					phase_d      = cbd_pkg::PH_DONE;
					stall_flag_d = 1'b1;
					cap_flag_d   = 1'b0;
				end
			end else begin
				idle_d = '0;
				case (phase_q)
					cbd_pkg::PH_SIZE: begin
						if (item.byte_value == cbd_pkg::CH_LF) begin
							if (accum_q == '0) begin
								phase_d      = cbd_pkg::PH_DONE;
								stall_flag_d = 1'b0;
								cap_flag_d   = 1'b0;
							end else begin
								chunk_d = accum_q;
								phase_d = cbd_pkg::PH_DATA;
							end
							accum_d = '0;
							kept_d  = '0;
							open_d  = 1'b1;
						end else if (item.byte_value != cbd_pkg::CH_CR &&
							kept_q < KEPT_W'(LINE_KEEP)) begin
							kept_d = kept_q + 1'b1;
							if (open_q) begin
								if (!hx[4]) begin
									open_d = 1'b0;
								end else if (accum_q[cbd_pkg::SIZE_W-1 -: 4] != 4'd0) begin
									accum_d = cbd_pkg::SIZE_MAX;
								end else begin
									accum_d = {accum_q[cbd_pkg::SIZE_W-5:0], hx[3:0]};
								end
							end
						end
					end
					cbd_pkg::PH_DATA: begin
						total_d = total_q + 1'b1;
						chunk_d = chunk_q - 1'b1;
						if (chunk_d == '0) begin
							phase_d = cbd_pkg::PH_TRAIL1;
						end
						if (total_d >= cfg.body_cap) begin
							phase_d      = cbd_pkg::PH_DONE;
							stall_flag_d = 1'b0;
							cap_flag_d   = 1'b1;
						end
					end
					cbd_pkg::PH_TRAIL1: begin
						phase_d = cbd_pkg::PH_TRAIL2;
					end
					default: begin
						phase_d = cbd_pkg::PH_SIZE;
						accum_d = '0;
						kept_d  = '0;
						open_d  = 1'b1;
					end
				endcase
			end
		end
	end

	// result for the item being processed
	always_comb begin
		result.payload_valid = fire && active && !at_cap && !item.mode &&
			(phase_q == cbd_pkg::PH_DATA);
		result.payload_byte  = result.payload_valid ? item.byte_value : 8'd0;
		result.finished      = (phase_d != cbd_pkg::PH_SIZE) && (phase_d != cbd_pkg::PH_DATA) &&
			(phase_d != cbd_pkg::PH_TRAIL1) && (phase_d != cbd_pkg::PH_TRAIL2);
		result.stalled       = stall_flag_d;
		result.capped        = cap_flag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cbd_pkg::PH_SIZE;
			accum_q      <= '0;
			kept_q       <= '0;
			open_q       <= 1'b1;
			chunk_q      <= '0;
			total_q      <= '0;
			idle_q       <= '0;
			stall_flag_q <= 1'b0;
			cap_flag_q   <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			accum_q      <= accum_d;
			kept_q       <= kept_d;
			open_q       <= open_d;
			chunk_q      <= chunk_d;
			total_q      <= total_d;
			idle_q       <= idle_d;
			stall_flag_q <= stall_flag_d;
			cap_flag_q   <= cap_flag_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/http_chunked_body_deframer_unit.sv
// Top level of the chunked body deframer: input register, core, result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------
//  byte in   | byte_valid / byte_stall   | byte_item  (mode, byte_value)
//  result    | res_valid  / res_stall    | res_item   (payload + end flags)
//  config    | cfg_valid  / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle sustained while no result is held; one result per item, passed
// through the input register, then the core's state update into the result register.
// A stalled result holds the core; one further item waits in the input register.
// Reset clears all parse state and loads the register defaults; no warm-up pass.
// cfg_ready is always high.
`default_nettype none
module http_chunked_body_deframer_unit #(
	parameter int LINE_KEEP = cbd_pkg::LINE_KEEP_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         byte_valid,
	output logic                        byte_stall,
	input  cbd_pkg::cbd_in_t            byte_item,
	output logic                        res_valid,
	input  wire                         res_stall,
	output cbd_pkg::cbd_out_t           res_item,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire                         cfg_index,
	input  wire [cbd_pkg::CAP_W-1:0]    cfg_data
);

	logic               valid_s1;
	cbd_pkg::cbd_in_t   item_s1;
	logic               res_valid_q;
	cbd_pkg::cbd_out_t  res_item_q;
	cbd_pkg::cbd_out_t  core_res;
	cbd_pkg::cbd_cfg_t  cfg_q;
	logic               out_free;
	logic               fire;

	assign out_free   = !res_valid_q || !res_stall;
	assign fire       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_item   = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.body_cap    <= cbd_pkg::BODY_CAP_RST;
			cfg_q.stall_ticks <= cbd_pkg::STALL_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cbd_pkg::CFG_BODY_CAP:    cfg_q.body_cap    <= cfg_data;
				cbd_pkg::CFG_STALL_TICKS: cfg_q.stall_ticks <= cfg_data[cbd_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	cbd_core #(
		.LINE_KEEP(LINE_KEEP)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_item_q <= core_res;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/cbd_checker.sv
// Port-level checks for the chunked body deframer, bound to the top level.
`default_nettype none
module cbd_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      byte_stall,
	input wire                      res_valid,
	input wire                      res_stall,
	input cbd_pkg::cbd_out_t        res_item
);

	logic ended_q;
	logic res_take;

	assign res_take = res_valid && !res_stall;

	// set once a finished result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (res_take && res_item.finished) begin
			ended_q <= 1'b1;
		end
	end

	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && ended_q |-> res_item.finished && !res_item.payload_valid)
		else $error("result after end not finished or carries payload");

	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.stalled || res_item.capped) |->
			res_item.finished && !(res_item.stalled && res_item.capped))
		else $error("end flags inconsistent");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.payload_valid |-> res_item.payload_byte == 8'd0)
		else $error("payload byte nonzero without payload");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid && res_stall)
		else $error("input stalled without a held result");

endmodule

bind http_chunked_body_deframer_unit cbd_checker u_cbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_stall (byte_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_item   (res_item)
);
`default_nettype wire
